@@ rtl/lpkc_pkg.sv @@
// Package for the pen key cache: sizes, entry and result types, state encoding.
// No dependencies; lpkc_if, lpkc_ctrl and lru_pen_key_cache import it.
`timescale 1ns / 1ps
`default_nettype none
package lpkc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int COLOR_W       = 4;
    localparam int WIDTH_W       = 8;
    localparam int STYLE_W       = 4;
    localparam int STAMP_W       = 32;
    localparam int SLOT_W        = 4;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [WIDTH_W-1:0] width;
        logic [STYLE_W-1:0] style;
    } pen_key_t;

    typedef struct packed {
        pen_key_t           key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   re;
        idx_t   raddr;
        logic   we;
        idx_t   waddr;
        entry_t wdata;
    } mem_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        pen_key_t          old_key;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } ctrl_state_t;

endpackage
`default_nettype wire

@@ rtl/lpkc_if.sv @@
// Valid/ready channel interfaces for pen key requests and cache results.
// Depends on lpkc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lpkc_req_if
    import lpkc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pen_color;
    logic [WIDTH_W-1:0] pen_width;
    logic [STYLE_W-1:0] pen_style;

    modport source (output valid, pen_color, pen_width, pen_style, input ready);
    modport sink   (input valid, pen_color, pen_width, pen_style, output ready);
endinterface

interface lpkc_rsp_if
    import lpkc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [COLOR_W-1:0] old_color;
    logic [WIDTH_W-1:0] old_width;
    logic [STYLE_W-1:0] old_style;

    modport source (output valid, hit, slot, evicted, old_color, old_width, old_style,
                    input ready);
    modport sink   (input valid, hit, slot, evicted, old_color, old_width, old_style,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/lpkc_entry_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lpkc_entry_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/lpkc_ctrl.sv @@
// Request sequencer: scans the entry RAM one slot per cycle, finds match,
// first empty slot and LRU victim, then writes back. Uses lpkc_pkg, lpkc_req_if.
`timescale 1ns / 1ps
`default_nettype none
module lpkc_ctrl
    import lpkc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpkc_req_if.sink    req,
    output      mem_req_t mem_req,
    input  wire entry_t mem_rdata,
    output      logic   res_valid,
    input  wire logic   res_ready,
    output      result_t res
);

    localparam idx_t LAST_IDX = idx_t'(CACHE_ENTRIES - 1);

    ctrl_state_t            state_reg, state_next;
    pen_key_t               key_reg, key_next;
    idx_t                   cmp_idx_reg, cmp_idx_next;
    logic                   hit_reg, hit_next;
    idx_t                   match_idx_reg, match_idx_next;
    logic                   empty_found_reg, empty_found_next;
    idx_t                   empty_idx_reg, empty_idx_next;
    idx_t                   lru_idx_reg, lru_idx_next;
    logic [STAMP_W-1:0]     lru_stamp_reg, lru_stamp_next;
    pen_key_t               lru_key_reg, lru_key_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0]     counter_reg, counter_next;

    idx_t target_idx;
    logic evict;

    assign evict      = !hit_reg && !empty_found_reg;
    assign target_idx = hit_reg ? match_idx_reg :
                        (empty_found_reg ? empty_idx_reg : lru_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_idx_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready     = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.raddr = '0;
        mem_req.we    = 1'b0;
        mem_req.waddr = target_idx;
        mem_req.wdata = '{key: key_reg, stamp: counter_reg};
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready  = 1'b1;
                mem_req.re = req.valid;
            end
            ST_SCAN:
            begin
                mem_req.re    = (cmp_idx_reg != LAST_IDX);
                mem_req.raddr = cmp_idx_reg + idx_t'(1);
            end
            ST_WRITE:
            begin
                res_valid  = 1'b1;
                mem_req.we = res_ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.hit     = hit_reg;
        res.slot    = SLOT_W'(target_idx);
        res.evicted = evict;
        res.old_key = evict ? lru_key_reg : '0;
    end

    always_comb
    begin
        key_next         = key_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        match_idx_next   = match_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        lru_idx_next     = lru_idx_reg;
        lru_stamp_next   = lru_stamp_reg;
        lru_key_next     = lru_key_reg;
        valid_next       = valid_reg;
        counter_next     = counter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next.color   = req.pen_color;
                    key_next.width   = req.pen_width;
                    key_next.style   = req.pen_style;
                    cmp_idx_next     = '0;
                    hit_next         = 1'b0;
                    match_idx_next   = '0;
                    empty_found_next = 1'b0;
                    empty_idx_next   = '0;
                    lru_idx_next     = '0;
                    lru_stamp_next   = '1;
                    lru_key_next     = '0;
                end
            end
            ST_SCAN:
            begin
                if (valid_reg[cmp_idx_reg])
                begin
                    if (!hit_reg && mem_rdata.key == key_reg)
                    begin
                        hit_next       = 1'b1;
                        match_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == '0 || mem_rdata.stamp < lru_stamp_reg)
                    begin
                        lru_stamp_next = mem_rdata.stamp;
                        lru_idx_next   = cmp_idx_reg;
                        lru_key_next   = mem_rdata.key;
                    end
                end
                else if (!empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = cmp_idx_reg;
                end
                if (cmp_idx_reg != LAST_IDX)
                begin
                    cmp_idx_next = cmp_idx_reg + idx_t'(1);
                end
            end
            ST_WRITE:
            begin
                if (res_ready)
                begin
                    valid_next[target_idx] = 1'b1;
                    counter_next           = counter_reg + STAMP_W'(1);
                end
            end
            default:
            begin
                cmp_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            counter_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_reg         <= hit_next;
        match_idx_reg   <= match_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        lru_idx_reg     <= lru_idx_next;
        lru_stamp_reg   <= lru_stamp_next;
        lru_key_reg     <= lru_key_next;
    end

`ifndef SYNTHESIS
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |=> valid_reg[$past(mem_req.waddr)])
        else $error("written slot not marked valid");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> counter_reg == $past(counter_reg) + STAMP_W'(1))
        else $error("request counter did not advance on result");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.hit && res.evicted))
        else $error("hit reported together with eviction");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.evicted |-> &valid_reg)
        else $error("eviction while an empty slot exists");
`endif

endmodule
`default_nettype wire

@@ rtl/lru_pen_key_cache.sv @@
// Top level of the pen key cache: entry RAM, sequencer and result register.
// Depends on lpkc_pkg, lpkc_if, lpkc_entry_ram, lpkc_ctrl.
//
//   channel  dir  beat payload
//   req      in   pen_color[3:0], pen_width[7:0], pen_style[3:0]
//   rsp      out  hit, slot[3:0], evicted, old_color[3:0], old_width[7:0], old_style[3:0]
//
// Each request is launched, then reads every entry in turn through the single RAM
// read port, then writes back.
// Reset clears valid bits and the request counter at once; no clearing pass.
// A result waits in the output register; the next request is taken meanwhile,
// and write-back stalls only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module lru_pen_key_cache
    import lpkc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpkc_req_if.sink   req,
    lpkc_rsp_if.source rsp
);

    mem_req_t mem_req;
    entry_t   mem_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg, out_data_next;

    lpkc_entry_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    lpkc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_data_reg.hit;
    assign rsp.slot      = out_data_reg.slot;
    assign rsp.evicted   = out_data_reg.evicted;
    assign rsp.old_color = out_data_reg.old_key.color;
    assign rsp.old_width = out_data_reg.old_key.width;
    assign rsp.old_style = out_data_reg.old_key.style;

endmodule
`default_nettype wire
